// ===== src/swmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

  localparam int unsigned NumLanes         = 4;
  localparam int unsigned SampleBits       = 16;
  localparam int unsigned WindowMaxDefault = 32;
  localparam int unsigned CfgIdxBits       = 8;
  localparam int unsigned CfgDataBits      = 8;
  localparam int unsigned WidthFieldBits   = 6;
  localparam int unsigned WidthReset       = 32;

  typedef enum logic [CfgIdxBits-1:0] {
    RegExtremumMode = 8'd0,
    RegWindowWidth  = 8'd1
  } cfg_reg_e;

  typedef logic signed [SampleBits-1:0] sample_t;

  // Per-request controls shared by all lanes.
  typedef struct packed {
    logic shift;  // a request is taken: window shifts by one
    logic mode;   // 0 = min, 1 = max
  } lane_ctl_t;

  // Neutral value for masked taps: most positive for min, most negative for max.
  function automatic sample_t identity_value(logic mode);
    sample_t v;
    v = {mode, {(SampleBits-1){~mode}}};
    return v;
  endfunction

  function automatic sample_t pick_extremum(sample_t a, sample_t b, logic mode);
    logic take_b;
    take_b = mode ? (b > a) : (b < a);
    return take_b ? b : a;
  endfunction

endpackage

`default_nettype wire

// ===== src/swmm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swmm_in_if;
  import swmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_lane0;
  sample_t sample_lane1;
  sample_t sample_lane2;
  sample_t sample_lane3;
  modport source (output valid, sample_lane0, sample_lane1, sample_lane2, sample_lane3,
                  input ready);
  modport sink   (input valid, sample_lane0, sample_lane1, sample_lane2, sample_lane3,
                  output ready);
endinterface

interface swmm_out_if;
  import swmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t extremum_lane0;
  sample_t extremum_lane1;
  sample_t extremum_lane2;
  sample_t extremum_lane3;
  modport source (output valid, extremum_lane0, extremum_lane1, extremum_lane2,
                  extremum_lane3, input ready);
  modport sink   (input valid, extremum_lane0, extremum_lane1, extremum_lane2,
                  extremum_lane3, output ready);
endinterface

interface swmm_cfg_if;
  import swmm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/swmm_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One lane: tapped shift line holding the window, then a registered
// compare tree, one tree level per pipeline stage.
module swmm_lane #(
  parameter int unsigned WindowMax = swmm_pkg::WindowMaxDefault
) (
  input  wire logic                                clk_i,
  input  wire swmm_pkg::lane_ctl_t                 ctl_i,
  input  wire logic [$clog2(WindowMax+1)-1:0]      width_i,
  input  wire logic [$clog2(WindowMax)-1:0]        stage_ld_i,
  input  wire swmm_pkg::sample_t                   sample_i,
  output swmm_pkg::sample_t                        extremum_o
);
  import swmm_pkg::*;

  localparam int unsigned WinBits = $clog2(WindowMax + 1);
  localparam int unsigned Levels  = $clog2(WindowMax);
  localparam int unsigned Pad     = 1 << Levels;

  sample_t tap_q  [WindowMax];
  sample_t leaf   [Pad];
  sample_t node_q [1:Pad-1];
  sample_t ident;

  assign ident = identity_value(ctl_i.mode);

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      tap_q[0] <= sample_i;
      for (int k = 1; k < WindowMax; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  // taps past the active width read as neutral
  for (genvar k = 0; k < Pad; k++) begin : g_leaf
    if (k < WindowMax) begin : g_tap
      assign leaf[k] = (width_i > WinBits'(k)) ? tap_q[k] : ident;
    end else begin : g_pad
      assign leaf[k] = ident;
    end
  end

  // heap order: node i has children 2i and 2i+1, leaves follow the last node
  for (genvar i = 1; i < Pad; i++) begin : g_node
    localparam int unsigned Stage = Levels - $clog2(i + 1);
    sample_t a;
    sample_t b;
    if (i >= Pad / 2) begin : g_from_leaf
      assign a = leaf[2*i - Pad];
      assign b = leaf[2*i + 1 - Pad];
    end else begin : g_from_node
      assign a = node_q[2*i];
      assign b = node_q[2*i + 1];
    end
    always_ff @(posedge clk_i) begin
      if (stage_ld_i[Stage]) begin
        node_q[i] <= pick_extremum(a, b, ctl_i.mode);
      end
    end
  end

  assign extremum_o = node_q[1];

endmodule

`default_nettype wire

// ===== src/swmm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Configuration registers, fill tracking and the stage valid/ready chain.
module swmm_ctrl #(
  parameter int unsigned WindowMax = swmm_pkg::WindowMaxDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [swmm_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire logic [swmm_pkg::CfgDataBits-1:0]    cfg_data_i,
  output swmm_pkg::lane_ctl_t                      lane_ctl_o,
  output logic [$clog2(WindowMax+1)-1:0]           width_o,
  output logic [$clog2(WindowMax)-1:0]             stage_ld_o
);
  import swmm_pkg::*;

  localparam int unsigned WinBits  = $clog2(WindowMax + 1);
  localparam int unsigned Levels   = $clog2(WindowMax);
  localparam int unsigned WidthRst = (WidthReset > WindowMax) ? WindowMax : WidthReset;

  logic               mode_q, mode_d;
  logic [WinBits-1:0] width_q, width_d;
  logic [WinBits-1:0] fill_q, fill_d;
  logic [Levels-1:0]  valid_q, valid_d;
  logic [Levels-1:0]  ld;
  logic [WidthFieldBits-1:0] wdat;
  logic [WinBits-1:0] width_new;
  logic               in_acc, cfg_acc, full, launch;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign full        = (fill_q == width_q);

  // a stage loads when empty or when its content moves on
  for (genvar s = 0; s < Levels; s++) begin : g_ld
    if (s == Levels - 1) begin : g_last
      assign ld[s] = ~valid_q[s] | out_ready_i;
    end else begin : g_mid
      assign ld[s] = ~valid_q[s] | ld[s+1];
    end
  end

  assign in_ready_o  = ld[0];
  assign in_acc      = in_valid_i & in_ready_o;
  assign launch      = in_acc & full;
  assign out_valid_o = valid_q[Levels-1];
  assign stage_ld_o  = ld;
  assign width_o     = width_q;
  assign lane_ctl_o  = '{shift: in_acc, mode: mode_q};

  always_comb begin
    wdat = cfg_data_i[WidthFieldBits-1:0];
    if (wdat == '0) begin
      width_new = WinBits'(1);
    end else if (32'(wdat) > WindowMax) begin
      width_new = WinBits'(WindowMax);
    end else begin
      width_new = WinBits'(wdat);
    end
  end

  always_comb begin
    mode_d  = mode_q;
    width_d = width_q;
    fill_d  = fill_q;
    if (in_acc && !full) begin
      fill_d = fill_q + WinBits'(1);
    end
    if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegExtremumMode: mode_d = cfg_data_i[0];
        RegWindowWidth: begin
          width_d = width_new;
          fill_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int s = 0; s < Levels; s++) begin
      if (ld[s]) begin
        valid_d[s] = (s == 0) ? launch : valid_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      width_q <= WinBits'(WidthRst);
      fill_q  <= '0;
      valid_q <= '0;
    end else begin
      mode_q  <= mode_d;
      width_q <= width_d;
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= width_q)
    else $error("fill count above window width");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q != '0) && (32'(width_q) <= WindowMax))
    else $error("active width out of range");

  a_fill_no_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !full) |=> !valid_q[0])
    else $error("fill request produced a result");

  a_width_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_acc && cfg_reg_e'(cfg_index_i) == RegWindowWidth) |=> (fill_q == '0))
    else $error("window not emptied on width write");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

// ===== src/sliding_window_min_max_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Modport  Payload                           Handshake
// sample_i  sink     sample_lane0..3, signed 16 bit    valid / ready
// result_o  source   extremum_lane0..3, signed 16 bit  valid / ready
// cfg_i     sink     index (8 bit), data (8 bit)       valid / ready
//
// Takes one request per cycle while input ready is high. A result leaves once
// it has passed the compare tree, which has one registered level per stage.
// Reset empties the window: the first window_width requests give no result.
// The stage valid chain collapses bubbles, so requests keep flowing while a
// result waits; input ready drops only when every stage holds a result.
module sliding_window_min_max_filter_core #(
  parameter int unsigned WindowMax = swmm_pkg::WindowMaxDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  swmm_in_if.sink   sample_i,
  swmm_out_if.source result_o,
  swmm_cfg_if.sink  cfg_i
);
  import swmm_pkg::*;

  localparam int unsigned WinBits = $clog2(WindowMax + 1);
  localparam int unsigned Levels  = $clog2(WindowMax);

  lane_ctl_t          lane_ctl;
  logic [WinBits-1:0] width;
  logic [Levels-1:0]  stage_ld;
  sample_t            samples   [NumLanes];
  sample_t            extremums [NumLanes];

  // fill tracking, config and stage flow control
  swmm_ctrl #(
    .WindowMax (WindowMax)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .lane_ctl_o  (lane_ctl),
    .width_o     (width),
    .stage_ld_o  (stage_ld)
  );

  assign samples[0] = sample_i.sample_lane0;
  assign samples[1] = sample_i.sample_lane1;
  assign samples[2] = sample_i.sample_lane2;
  assign samples[3] = sample_i.sample_lane3;

  // identical lanes, all stepped by the same controls
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    swmm_lane #(
      .WindowMax (WindowMax)
    ) u_lane (
      .clk_i      (clk_i),
      .ctl_i      (lane_ctl),
      .width_i    (width),
      .stage_ld_i (stage_ld),
      .sample_i   (samples[l]),
      .extremum_o (extremums[l])
    );
  end

  // merge: lane roots form the result request
  assign result_o.extremum_lane0 = extremums[0];
  assign result_o.extremum_lane1 = extremums[1];
  assign result_o.extremum_lane2 = extremums[2];
  assign result_o.extremum_lane3 = extremums[3];

endmodule

`default_nettype wire

// ===== tb/tb_sliding_window_min_max_filter_core.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_min_max_filter_core;
  import swmm_pkg::*;

  // All four lanes of one request or one result, lane 0 in the low bits.
  typedef logic [NumLanes-1:0][SampleBits-1:0] lane_word_t;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned SettleCycles  = 16;    // > compare tree depth of 5
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RegimeItems   = 260;

  // Scoreboard: tracks the window contents and predicts the running extremum.
  class extremum_scoreboard;
    sample_t                   taps [NumLanes][WindowMaxDefault];
    int unsigned               fill_level;
    int unsigned               ring_pos;
    logic                      mode_max;
    logic [WidthFieldBits-1:0] width_reg;
    lane_word_t                expected_extrema [$];
    int unsigned               mismatches;
    int unsigned               leftovers;
    int unsigned               samples_taken;
    int unsigned               results_checked;
    int unsigned               reg_writes;

    function new();
      mode_max        = 1'b0;
      width_reg       = WidthFieldBits'(WidthReset);
      fill_level      = 0;
      ring_pos        = 0;
      mismatches      = 0;
      leftovers       = 0;
      samples_taken   = 0;
      results_checked = 0;
      reg_writes      = 0;
    endfunction

    // Width 0 acts as 1, anything past the window depth is clamped.
    function int unsigned window_len();
      if (width_reg == 0) return 1;
      if (width_reg > WindowMaxDefault) return WindowMaxDefault;
      return width_reg;
    endfunction

    function int unsigned pending();
      return expected_extrema.size();
    endfunction

    function void configure(cfg_reg_e idx, logic [CfgDataBits-1:0] data);
      reg_writes++;
      case (idx)
        RegExtremumMode: mode_max = data[0];
        RegWindowWidth: begin
          width_reg  = data[WidthFieldBits-1:0];
          fill_level = 0;
          ring_pos   = 0;
        end
        default: ;
      endcase
    endfunction

    function void note_sample(lane_word_t s);
      int unsigned w;
      int unsigned pos;
      lane_word_t  ext;
      sample_t     best;
      sample_t     x;
      w   = window_len();
      pos = ring_pos % w;
      samples_taken++;
      if (fill_level < w) begin
        for (int lane = 0; lane < NumLanes; lane++) taps[lane][pos] = s[lane];
        fill_level++;
      end else begin
        for (int lane = 0; lane < NumLanes; lane++) begin
          best = taps[lane][0];
          for (int unsigned k = 1; k < w; k++) begin
            x = taps[lane][k];
            if (mode_max ? (x > best) : (x < best)) best = x;
          end
          ext[lane]       = best;
          taps[lane][pos] = s[lane];
        end
        expected_extrema.push_back(ext);
      end
      ring_pos = (pos + 1) % w;
    endfunction

    function void check_result(lane_word_t got);
      lane_word_t  want;
      logic [NumLanes-1:0] bad_lanes;
      results_checked++;
      if (expected_extrema.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result %h, nothing outstanding", $realtime, got);
        return;
      end
      want = expected_extrema.pop_front();
      for (int lane = 0; lane < NumLanes; lane++)
        bad_lanes[lane] = (want[lane] !== got[lane]);
      if (bad_lanes != '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result mismatch, lanes %b: ",
                    "expected %0d %0d %0d %0d, got %0d %0d %0d %0d"},
                   $realtime, bad_lanes,
                   $signed(want[0]), $signed(want[1]), $signed(want[2]), $signed(want[3]),
                   $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
      end
    endfunction

    function void finish_check();
      leftovers = expected_extrema.size();
      if (leftovers != 0) $display("%0d expected results never arrived", leftovers);
    endfunction

    function bit failed();
      return (mismatches != 0) || (leftovers != 0);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  swmm_in_if  sample_if ();
  swmm_out_if result_if ();
  swmm_cfg_if cfg_if ();

  sliding_window_min_max_filter_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  extremum_scoreboard window_check = new();

  // Percent of cycles in which the sender / receiver hold off.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned quiet_cycles  = 0;

  always #(HalfPeriod) clk_i = ~clk_i;

  // Receiver: ready picked fresh at every falling edge.
  always @(negedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Result check at the rising edge, on pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      window_check.check_result({result_if.extremum_lane3, result_if.extremum_lane2,
                                 result_if.extremum_lane1, result_if.extremum_lane0});
  end

  // Watchdog: any accepted request on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("Watchdog: no progress for %0d cycles", WatchdogLimit);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // All driving tasks start and end on a falling edge.
  task automatic push_sample(lane_word_t s);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    sample_if.valid        = 1'b1;
    sample_if.sample_lane0 = s[0];
    sample_if.sample_lane1 = s[1];
    sample_if.sample_lane2 = s[2];
    sample_if.sample_lane3 = s[3];
    do @(posedge clk_i); while (!sample_if.ready);
    window_check.note_sample(s);
    @(negedge clk_i);
    sample_if.valid = 1'b0;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataBits-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    window_check.configure(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (window_check.pending() != 0) @(negedge clk_i);
  endtask

  // Filling requests leave no result behind, so give the pipe time to empty.
  task automatic quiesce();
    wait_results_drained();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic lane_word_t lanes(int a, int b, int c, int d);
    return {16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  // Mix of rails, near-zero values (lots of ties) and full-range noise.
  function automatic logic [SampleBits-1:0] rand_lane();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return 16'($urandom_range(7)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic lane_word_t rand_item();
    lane_word_t s;
    for (int lane = 0; lane < NumLanes; lane++) s[lane] = rand_lane();
    if ($urandom_range(15) == 0) s = {NumLanes{s[0]}};
    return s;
  endfunction

  // Mostly short windows; now and then the full depth or an out-of-range code.
  // Upper data bits are random: only the low six bits carry the width.
  function automatic logic [CfgDataBits-1:0] rand_width_data();
    logic [CfgDataBits-1:0] d;
    d = 8'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: d[5:0] = 6'($urandom_range(1, 8));
      6:                d[5:0] = 6'($urandom_range(9, 31));
      7:                d[5:0] = 6'd32;
      8:                d[5:0] = 6'd0;
      default:          d[5:0] = 6'($urandom_range(33, 63));
    endcase
    return d;
  endfunction

  task automatic reconfigure();
    quiesce();
    write_reg(RegExtremumMode, 8'($urandom));
    // Sometimes only the mode changes so the stored window carries over.
    if ($urandom_range(3) != 0) write_reg(RegWindowWidth, rand_width_data());
  endtask

  task automatic run_regime(int unsigned src_pct, int unsigned sink_pct, int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    sent          = 0;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (sent < n_items) begin
      reconfigure();
      burst = window_check.window_len() + $urandom_range(12, 48);
      repeat (burst) begin
        // Occasional hold-off until the result side has caught up.
        if ($urandom_range(79) == 0) wait_results_drained();
        push_sample(rand_item());
      end
      sent += burst;
    end
  endtask

  initial begin
    sample_if.valid        = 1'b0;
    sample_if.sample_lane0 = '0;
    sample_if.sample_lane1 = '0;
    sample_if.sample_lane2 = '0;
    sample_if.sample_lane3 = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = RegExtremumMode;
    cfg_if.data            = '0;
    result_if.ready        = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: rails and ties over a width-3 min window.
    write_reg(RegExtremumMode, 8'h00);
    write_reg(RegWindowWidth, 8'd3);
    push_sample(lanes(-32768, 32767, 0, -1));
    push_sample(lanes(32767, -32768, 1, 0));
    push_sample(lanes(0, -1, -32768, 32767));
    push_sample(lanes(-1, 0, 32767, -32768));
    push_sample(lanes(1, 1, 1, 1));
    push_sample(lanes(-32768, -32768, 32767, 32767));
    push_sample(lanes(32767, 32767, -32768, -32768));

    // Switch to max with the window kept: results follow at once.
    quiesce();
    write_reg(RegExtremumMode, 8'h01);
    push_sample(lanes(0, 0, 0, 0));
    push_sample(lanes(-2, 5, -32768, 32767));
    push_sample(lanes(7, -7, 3, -3));

    // Mode from bit 0 only; width code 0 behaves as a one-sample window.
    quiesce();
    write_reg(RegExtremumMode, 8'hfe);
    write_reg(RegWindowWidth, 8'hc0);
    push_sample(lanes(32767, -32768, 100, -100));
    push_sample(lanes(-32768, 32767, -100, 100));
    push_sample(lanes(5, 5, 5, 5));
    push_sample(lanes(-5, 6, -7, 8));

    // Two-sample max window.
    quiesce();
    write_reg(RegExtremumMode, 8'h01);
    write_reg(RegWindowWidth, 8'd2);
    push_sample(lanes(-32768, -32768, -32768, -32768));
    push_sample(lanes(-32767, 32767, 0, -1));
    push_sample(lanes(32767, -32768, -1, 0));
    push_sample(lanes(0, 0, 0, 0));

    // Random part under three stall patterns.
    run_regime(35, 64, RegimeItems);
    run_regime(64, 35, RegimeItems);
    run_regime(0, 0, RegimeItems);

    src_idle_pct = 0;
    quiesce();
    window_check.finish_check();

    $display("Covered %0d sample requests, %0d checked results, %0d register writes;",
             window_check.samples_taken, window_check.results_checked,
             window_check.reg_writes);
    $display({"min and max modes, windows of 1 to 32 incl. out-of-range width codes, ",
              "three stall mixes."});
    if (!window_check.failed()) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
